@@ design/lrumc_pkg.sv @@
// Shared constants, types and helpers of the LRU miss counter.
package lrumc_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_WIDTH = 32;
    localparam int REQ_W     = 32;
    localparam int CAP_W     = 5;
    localparam int OCC_W     = 5;
    localparam int MISS_W    = 32;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
    localparam logic [MISS_W-1:0] MISS_MAX  = {MISS_W{1'b1}};

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [CNT_W-1:0]     t_cnt;

    // Control broadcast from the top level to one cell.
    typedef struct packed {
        logic load;
        logic any_hit;
        logic in_use;
        logic shift_lim;
    } t_cell_ctrl;

    function automatic t_key key_of(input logic [REQ_W-1:0] req);
        key_of = t_key'(req);
    endfunction

    // Capacity register value clamped to the range 1 .. ENTRIES.
    function automatic t_cnt eff_cap(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cap);
        if (c == '0) begin
            c = CMP_W'(1);
        end
        if (c > CMP_W'(ENTRIES)) begin
            c = CMP_W'(ENTRIES);
        end
        eff_cap = t_cnt'(c);
    endfunction

endpackage

@@ design/lru_replacement_miss_counter.sv @@
// Top level of the fully associative LRU cache with saturating miss counter.
// One request transaction is accepted per clock cycle, and its result appears
// in the output register in the cycle after acceptance. The rate is set by the
// row of ENTRIES key cells: every request is compared against all cells at
// once, a priority chain through the cells picks the most recent match, and
// the stack shifts by one position in the same cycle. A result waiting in the
// output register blocks new requests only while the consumer stalls.
// The capacity register is written with i_cfg_we and should only change while
// no request is in flight.
module lru_replacement_miss_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lrumc_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lrumc_pkg::REQ_W-1:0]   i_request_key,
    input  logic                          i_end_of_run,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [lrumc_pkg::MISS_W-1:0]  o_miss_count,
    output logic [lrumc_pkg::OCC_W-1:0]   o_occupancy
);
    import lrumc_pkg::*;

    logic [CAP_W-1:0]  r_capacity;
    t_cnt              r_count;
    t_cnt              n_count;
    logic [MISS_W-1:0] r_misses;
    logic [MISS_W-1:0] n_misses;
    logic              r_out_valid;
    logic              r_hit;
    logic [MISS_W-1:0] r_miss_out;
    t_cnt              r_occ_out;

    logic       w_accept;
    t_key       w_key;
    t_cnt       w_cap;
    t_cnt       w_cnt;
    t_cnt       w_top;
    t_cnt       w_cnt_after;
    logic [MISS_W-1:0] w_miss_after;
    logic       w_any_hit;

    t_key       w_keys  [ENTRIES];
    logic       w_found [ENTRIES+1];
    t_cell_ctrl w_ctrl  [ENTRIES];

    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_key      = key_of(i_request_key);

    // Occupancy above a lowered capacity is trimmed before lookup.
    assign w_cap = eff_cap(r_capacity);
    assign w_cnt = (r_count > w_cap) ? w_cap : r_count;
    assign w_top = (w_cnt >= w_cap) ? (w_cap - t_cnt'(1)) : w_cnt;

    assign w_found[0] = 1'b0;
    assign w_any_hit  = w_found[ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            t_key w_prev;
            if (gi == 0) begin : g_head
                assign w_prev = w_key;
            end else begin : g_link
                assign w_prev = w_keys[gi-1];
            end

            assign w_ctrl[gi].load      = w_accept;
            assign w_ctrl[gi].any_hit   = w_any_hit;
            assign w_ctrl[gi].in_use    = t_cnt'(gi) < w_cnt;
            assign w_ctrl[gi].shift_lim = t_cnt'(gi) <= w_top;

            lrumc_cell u_cell (
                .i_clk       (i_clk),
                .i_req_key   (w_key),
                .i_prev_key  (w_prev),
                .i_found_in  (w_found[gi]),
                .i_ctrl      (w_ctrl[gi]),
                .o_found_out (w_found[gi+1]),
                .o_key       (w_keys[gi])
            );
        end
    endgenerate

    assign w_cnt_after  = w_any_hit ? w_cnt : (w_top + t_cnt'(1));
    assign w_miss_after = (w_any_hit || r_misses == MISS_MAX) ? r_misses
                                                               : (r_misses + MISS_W'(1));

    always_comb begin
        n_count  = r_count;
        n_misses = r_misses;
        if (w_accept) begin
            if (i_end_of_run) begin
                n_count  = '0;
                n_misses = '0;
            end else begin
                n_count  = w_cnt_after;
                n_misses = w_miss_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_count  <= n_count;
            r_misses <= n_misses;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit      <= w_any_hit;
            r_miss_out <= w_miss_after;
            r_occ_out  <= w_cnt_after;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_miss_count = r_miss_out;
    assign o_occupancy  = OCC_W'(r_occ_out);

endmodule

@@ design/lrumc_cell.sv @@
// One position of the recency stack: holds a key, compares and shifts.
module lrumc_cell (
    input  logic                i_clk,
    input  lrumc_pkg::t_key     i_req_key,
    input  lrumc_pkg::t_key     i_prev_key,
    input  logic                i_found_in,
    input  lrumc_pkg::t_cell_ctrl i_ctrl,
    output logic                o_found_out,
    output lrumc_pkg::t_key     o_key
);
    import lrumc_pkg::*;

    t_key r_key;
    t_key n_key;
    logic w_match;
    logic w_shift;

    assign w_match     = i_ctrl.in_use && (r_key == i_req_key);
    assign o_found_out = i_found_in | w_match;

    // Cells up to and including the hit position, or up to the insertion
    // limit on a miss, take the key of their more recent neighbor.
    assign w_shift = i_ctrl.load && !i_found_in && (i_ctrl.any_hit || i_ctrl.shift_lim);

    always_comb begin
        n_key = r_key;
        if (w_shift) begin
            n_key = i_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

@@ design/lrumc_checker.sv @@
// Port-level assertions for the LRU miss counter, bound to the top level.
module lrumc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic                          o_hit,
    input  logic [lrumc_pkg::MISS_W-1:0]  o_miss_count,
    input  logic [lrumc_pkg::OCC_W-1:0]   o_occupancy
);
    import lrumc_pkg::*;

    // Reset leaves no result transaction pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Every accepted request shows a result in the following cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request produced no result");

    // A miss always counts and always leaves at least one entry.
    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_miss_count != '0 && o_occupancy != '0))
        else $error("miss result with zero count or empty store");

    // A hit requires a resident entry.
    a_hit_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_occupancy != '0))
        else $error("hit reported with empty store");

    // A stalled result transaction holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_miss_count) && $stable(o_hit) && $stable(o_occupancy)))
        else $error("stalled result changed");

endmodule

bind lru_replacement_miss_counter lrumc_checker u_lrumc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_hit        (o_hit),
    .o_miss_count (o_miss_count),
    .o_occupancy  (o_occupancy)
);

@@ tb/lru_replacement_miss_counter_checker.sv @@
// Watches the request and result channels, predicts each lookup and compares.
module lru_replacement_miss_counter_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lrumc_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [lrumc_pkg::REQ_W-1:0]  i_request_key,
    input  logic                         i_end_of_run,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_hit,
    input  logic [lrumc_pkg::MISS_W-1:0] i_miss_count,
    input  logic [lrumc_pkg::OCC_W-1:0]  i_occupancy,
    output int                           o_fail_count,
    output int                           o_pending
);
    import lrumc_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [MISS_W-1:0] misses;
        logic [OCC_W-1:0]  occupancy;
    } t_lookup_result;

    // Position 0 holds the most recently used key.
    t_key              recency_stack [ENTRIES];
    int                resident_count;
    logic [MISS_W-1:0] run_misses;
    logic [CAP_W-1:0]  capacity_reg;
    t_lookup_result    expected_lookups [$];
    int                fails;

    function automatic t_lookup_result lookup_and_update(input t_key key, input logic last);
        int             cap;
        int             slot;
        int             top;
        t_lookup_result r;
        cap = (capacity_reg == '0) ? 1 : ((capacity_reg > ENTRIES) ? ENTRIES : capacity_reg);
        // A capacity lowered while idle trims the least recent entries here.
        if (resident_count > cap) begin
            resident_count = cap;
        end
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && i < resident_count && recency_stack[i] == key) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            for (int i = slot; i > 0; i--) begin
                recency_stack[i] = recency_stack[i-1];
            end
            r.hit = 1'b1;
        end else begin
            top = (resident_count >= cap) ? cap - 1 : resident_count;
            for (int i = top; i > 0; i--) begin
                recency_stack[i] = recency_stack[i-1];
            end
            resident_count = top + 1;
            if (run_misses != '1) begin
                run_misses = run_misses + 1'b1;
            end
            r.hit = 1'b0;
        end
        recency_stack[0] = key;
        r.misses    = run_misses;
        r.occupancy = OCC_W'(resident_count);
        if (last) begin
            resident_count = 0;
            run_misses     = '0;
        end
        return r;
    endfunction

    task automatic record_failure(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_lookup_result want;
        if (!i_rst_n) begin
            expected_lookups.delete();
            resident_count = 0;
            run_misses     = '0;
            capacity_reg   = CAP_RESET;
        end else begin
            // Results are retired before new requests are predicted.
            if (i_out_valid && i_out_ready) begin
                if (expected_lookups.size() == 0) begin
                    record_failure($sformatf("unexpected result hit=%0b misses=%0d occ=%0d",
                                             i_hit, i_miss_count, i_occupancy));
                end else begin
                    want = expected_lookups.pop_front();
                    if (i_hit !== want.hit) begin
                        record_failure($sformatf("hit expected %0b got %0b", want.hit, i_hit));
                    end
                    if (i_miss_count !== want.misses) begin
                        record_failure($sformatf("miss_count expected %0d got %0d",
                                                 want.misses, i_miss_count));
                    end
                    if (i_occupancy !== want.occupancy) begin
                        record_failure($sformatf("occupancy expected %0d got %0d",
                                                 want.occupancy, i_occupancy));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_lookups = {expected_lookups,
                                    lookup_and_update(t_key'(i_request_key), i_end_of_run)};
            end
            if (i_cfg_we) begin
                capacity_reg = i_cfg_data;
            end
        end
        o_pending    <= expected_lookups.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/lru_replacement_miss_counter_test.sv @@
// Stimulus and verdict for the LRU cache miss counter, checked by a side monitor.
module lru_replacement_miss_counter_test;

    import lrumc_pkg::*;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CAP_W-1:0]  cfg_data  = '0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    logic [REQ_W-1:0]  req_key   = '0;
    logic              req_last  = 1'b0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    logic              res_hit;
    logic [MISS_W-1:0] res_miss_count;
    logic [OCC_W-1:0]  res_occupancy;
    int                fail_count;
    int                pending;
    logic              idle_en   = 1'b1;
    int                stall_left = 0;

    lru_replacement_miss_counter i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (req_valid),
        .o_in_ready    (req_ready),
        .i_request_key (req_key),
        .i_end_of_run  (req_last),
        .o_out_valid   (res_valid),
        .i_out_ready   (res_ready),
        .o_hit         (res_hit),
        .o_miss_count  (res_miss_count),
        .o_occupancy   (res_occupancy)
    );

    lru_replacement_miss_counter_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (req_valid),
        .i_in_ready    (req_ready),
        .i_request_key (req_key),
        .i_end_of_run  (req_last),
        .i_out_valid   (res_valid),
        .i_out_ready   (res_ready),
        .i_hit         (res_hit),
        .i_miss_count  (res_miss_count),
        .i_occupancy   (res_occupancy),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    // Consumer stalls come in bursts while idling is enabled.
    always @(posedge clk) begin
        if (!idle_en) begin
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if (rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
        end
        res_ready <= (stall_left == 0);
    end

    task automatic send_request(input logic [REQ_W-1:0] key, input logic last);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_key   <= key;
        req_last  <= last;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // Drains every outstanding transaction before the edge that writes the register.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_traffic(input logic [CAP_W-1:0] cap_value, input int count,
                               input logic calm);
        logic [REQ_W-1:0] pool [32];
        int               cap_eff;
        int               pool_size;
        logic [REQ_W-1:0] key;
        write_capacity(cap_value);
        cap_eff   = (cap_value == 0) ? 1 : ((cap_value > ENTRIES) ? ENTRIES : cap_value);
        pool_size = cap_eff + $urandom_range(0, 4);
        pool[0]   = $urandom;
        // Some keys differ from an earlier one in a single bit.
        for (int i = 1; i < pool_size; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                pool[i] = pool[$urandom_range(0, i - 1)] ^ (32'h1 << $urandom_range(0, 31));
            end else begin
                pool[i] = $urandom;
            end
        end
        for (int n = 0; n < count; n++) begin
            if (calm) begin
                idle_en <= 1'b0;
            end else if (n % 40 == 0) begin
                idle_en <= ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) < 8) begin
                key = pool[$urandom_range(0, pool_size - 1)];
            end else begin
                key = $urandom;
            end
            send_request(key, $urandom_range(0, 59) == 0);
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Full capacity after reset: extremes of the key and an end of run.
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'hFFFF_FFFE, 1'b0);
        send_request(32'hAAAA_AAAA, 1'b0);
        send_request(32'h5555_5555, 1'b1);
        send_request(32'h0000_0000, 1'b0);

        // Two entries: eviction of the least recent key.
        write_capacity(5'd2);
        send_request(32'h1234_5678, 1'b0);
        send_request(32'h9ABC_DEF0, 1'b0);
        send_request(32'h0F0F_0F0F, 1'b0);
        send_request(32'h1234_5678, 1'b0);
        send_request(32'h0F0F_0F0F, 1'b1);

        // A zero capacity behaves as a single entry.
        write_capacity(5'd0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0002, 1'b0);

        // Oversized capacity, then shrinking below the current occupancy.
        write_capacity(5'd31);
        send_request(32'h0000_0100, 1'b0);
        send_request(32'h0000_0101, 1'b0);
        send_request(32'h0000_0102, 1'b0);
        send_request(32'h0000_0103, 1'b0);
        write_capacity(5'd2);
        send_request(32'h0000_0100, 1'b0);
        send_request(32'h0000_0103, 1'b0);

        run_traffic(5'd16, 100, 1'b0);
        run_traffic(5'd1,  100, 1'b0);
        run_traffic(5'd0,  100, 1'b0);
        run_traffic(5'd31, 100, 1'b0);
        run_traffic(5'd17, 100, 1'b0);
        run_traffic(5'd5,  100, 1'b0);
        run_traffic(5'd2,  100, 1'b0);
        run_traffic(5'd12, 100, 1'b0);
        run_traffic(5'd16, 100, 1'b0);
        run_traffic(5'd3,  100, 1'b0);
        run_traffic(5'd8,  100, 1'b0);
        run_traffic(5'd16, 100, 1'b1);

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ lru_replacement_miss_counter.f @@
design/lrumc_pkg.sv
design/lrumc_cell.sv
design/lru_replacement_miss_counter.sv
design/lrumc_checker.sv
tb/lru_replacement_miss_counter_checker.sv
tb/lru_replacement_miss_counter_test.sv
